>>> hdl/srdiv_pkg.sv
// ----------------------------------------------------------------------------
// srdiv_pkg
// Shared types for the signed restoring divider pipeline.
// ----------------------------------------------------------------------------
package srdiv_pkg;

	// Sign and exception flags that travel with each item through the stages
	typedef struct packed {
		logic dividend_neg;
		logic divisor_neg;
		logic div_zero;
	} stage_flags_t;

endpackage

>>> hdl/srdiv_prep.sv
// ----------------------------------------------------------------------------
// srdiv_prep
// Input stage: takes operand magnitudes and records signs and the zero divisor.
// ----------------------------------------------------------------------------
module srdiv_prep import srdiv_pkg::*; #(
	parameter int unsigned WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [WIDTH-1:0]   dividend,
	input  logic [WIDTH-1:0]   divisor,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [WIDTH:0]     rem_out,
	output logic [WIDTH-1:0]   quo_out,
	output logic [WIDTH-1:0]   mag_out,
	output stage_flags_t       flags_out
);

	logic               valid_s1;
	logic [WIDTH-1:0]   dividend_mag;
	logic [WIDTH-1:0]   divisor_mag;
	stage_flags_t       flags;
	logic [WIDTH-1:0]   quo_s1;
	logic [WIDTH-1:0]   mag_s1;
	stage_flags_t       flags_s1;

	always_comb begin
		dividend_mag       = dividend[WIDTH-1] ? (~dividend + WIDTH'(1'b1)) : dividend;
		divisor_mag        = divisor[WIDTH-1] ? (~divisor + WIDTH'(1'b1)) : divisor;
		flags.dividend_neg = dividend[WIDTH-1];
		flags.divisor_neg  = divisor[WIDTH-1];
		flags.div_zero     = (divisor == '0);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			quo_s1   <= dividend_mag;
			mag_s1   <= divisor_mag;
			flags_s1 <= flags;
		end
	end

	assign out_valid = valid_s1;
	assign rem_out   = '0;
	assign quo_out   = quo_s1;
	assign mag_out   = mag_s1;
	assign flags_out = flags_s1;

endmodule

>>> hdl/srdiv_step.sv
// ----------------------------------------------------------------------------
// srdiv_step
// One restoring division step: shift, trial subtract, keep or restore.
// ----------------------------------------------------------------------------
module srdiv_step import srdiv_pkg::*; #(
	parameter int unsigned WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [WIDTH:0]     rem_in,
	input  logic [WIDTH-1:0]   quo_in,
	input  logic [WIDTH-1:0]   mag_in,
	input  stage_flags_t       flags_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [WIDTH:0]     rem_out,
	output logic [WIDTH-1:0]   quo_out,
	output logic [WIDTH-1:0]   mag_out,
	output stage_flags_t       flags_out
);

	logic               valid_s1;
	logic [WIDTH:0]     rem_shift;
	logic [WIDTH+1:0]   diff;
	logic [WIDTH:0]     rem_next;
	logic [WIDTH-1:0]   quo_next;
	logic [WIDTH:0]     rem_s1;
	logic [WIDTH-1:0]   quo_s1;
	logic [WIDTH-1:0]   mag_s1;
	stage_flags_t       flags_s1;

	always_comb begin
		rem_shift = {rem_in[WIDTH-1:0], quo_in[WIDTH-1]};
		diff      = {1'b0, rem_shift} - {2'b00, mag_in};
		if (!diff[WIDTH+1]) begin
			rem_next = diff[WIDTH:0];
			quo_next = {quo_in[WIDTH-2:0], 1'b1};
		end else begin
			rem_next = rem_shift;
			quo_next = {quo_in[WIDTH-2:0], 1'b0};
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_s1   <= rem_next;
			quo_s1   <= quo_next;
			mag_s1   <= mag_in;
			flags_s1 <= flags_in;
		end
	end

	assign out_valid = valid_s1;
	assign rem_out   = rem_s1;
	assign quo_out   = quo_s1;
	assign mag_out   = mag_s1;
	assign flags_out = flags_s1;

endmodule

>>> hdl/srdiv_post.sv
// ----------------------------------------------------------------------------
// srdiv_post
// Output stage: applies result signs and forces zero results on a zero divisor.
// ----------------------------------------------------------------------------
module srdiv_post import srdiv_pkg::*; #(
	parameter int unsigned WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [WIDTH:0]     rem_in,
	input  logic [WIDTH-1:0]   quo_in,
	input  stage_flags_t       flags_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [WIDTH:0]     quotient,
	output logic [WIDTH-1:0]   remainder,
	output logic               divide_by_zero
);

	logic               valid_s1;
	logic [WIDTH:0]     quo_ext;
	logic [WIDTH-1:0]   rem_mag;
	logic [WIDTH:0]     quo_signed;
	logic [WIDTH-1:0]   rem_signed;
	logic [WIDTH:0]     quotient_s1;
	logic [WIDTH-1:0]   remainder_s1;
	logic               dz_s1;

	always_comb begin
		quo_ext = {1'b0, quo_in};
		rem_mag = rem_in[WIDTH-1:0];
		if (flags_in.div_zero) begin
			quo_signed = '0;
			rem_signed = '0;
		end else begin
			quo_signed = (flags_in.dividend_neg != flags_in.divisor_neg)
				? (~quo_ext + (WIDTH+1)'(1'b1)) : quo_ext;
			rem_signed = flags_in.dividend_neg ? (~rem_mag + WIDTH'(1'b1)) : rem_mag;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			quotient_s1  <= quo_signed;
			remainder_s1 <= rem_signed;
			dz_s1        <= flags_in.div_zero;
		end
	end

	assign out_valid      = valid_s1;
	assign quotient       = quotient_s1;
	assign remainder      = remainder_s1;
	assign divide_by_zero = dz_s1;

endmodule

>>> hdl/signed_restoring_divider.sv
// ----------------------------------------------------------------------------
// signed_restoring_divider
// Pipelined signed divider: one restoring step per stage, C sign rules.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: dividend, divisor
// m_*       out  m_tvalid/m_tready  tdata: quotient, remainder; tuser: divide_by_zero
//
// The pipeline has one magnitude stage, WIDTH step stages and one sign stage.
// A new operand pair is taken every cycle while the output side keeps up.
// Each stage holds its item while the next one is full and stalled; no item is lost.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module signed_restoring_divider import srdiv_pkg::*; #(
	parameter int unsigned WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// dividend [WIDTH-1:0], divisor [2*WIDTH-1:WIDTH], zero fill above
	input  logic [((2*WIDTH+7)/8)*8-1:0]         s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// quotient [WIDTH:0], remainder [2*WIDTH:WIDTH+1], zero fill above
	output logic [((2*WIDTH+8)/8)*8-1:0]         m_tdata,
	// divide_by_zero [0]
	output logic                                 m_tuser
);

	localparam int unsigned OUT_BITS = ((2*WIDTH+8)/8)*8;

	logic               valid_st [0:WIDTH];
	logic               ready_st [0:WIDTH];
	logic [WIDTH:0]     rem_st   [0:WIDTH];
	logic [WIDTH-1:0]   quo_st   [0:WIDTH];
	logic [WIDTH-1:0]   mag_st   [0:WIDTH];
	stage_flags_t       flags_st [0:WIDTH];
	logic [WIDTH:0]     quotient;
	logic [WIDTH-1:0]   remainder;

	srdiv_prep #(.WIDTH(WIDTH)) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.dividend  (s_tdata[WIDTH-1:0]),
		.divisor   (s_tdata[2*WIDTH-1:WIDTH]),
		.out_valid (valid_st[0]),
		.out_ready (ready_st[0]),
		.rem_out   (rem_st[0]),
		.quo_out   (quo_st[0]),
		.mag_out   (mag_st[0]),
		.flags_out (flags_st[0])
	);

	for (genvar i = 0; i < WIDTH; i++) begin : g_step
		srdiv_step #(.WIDTH(WIDTH)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_st[i]),
			.in_ready  (ready_st[i]),
			.rem_in    (rem_st[i]),
			.quo_in    (quo_st[i]),
			.mag_in    (mag_st[i]),
			.flags_in  (flags_st[i]),
			.out_valid (valid_st[i+1]),
			.out_ready (ready_st[i+1]),
			.rem_out   (rem_st[i+1]),
			.quo_out   (quo_st[i+1]),
			.mag_out   (mag_st[i+1]),
			.flags_out (flags_st[i+1])
		);
	end

	srdiv_post #(.WIDTH(WIDTH)) u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (valid_st[WIDTH]),
		.in_ready       (ready_st[WIDTH]),
		.rem_in         (rem_st[WIDTH]),
		.quo_in         (quo_st[WIDTH]),
		.flags_in       (flags_st[WIDTH]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.quotient       (quotient),
		.remainder      (remainder),
		.divide_by_zero (m_tuser)
	);

	assign m_tdata = OUT_BITS'({remainder, quotient});

endmodule
